### hw/rtl/bsa_pkg.sv
// shared types and constants for the bitmap slot allocator
package bsa_pkg;

  localparam int unsigned PoolSlots  = 1024;
  localparam int unsigned GroupSize  = 256;
  localparam int unsigned NumGroups  = PoolSlots / GroupSize;
  localparam int unsigned MapBytes   = PoolSlots / 8;
  localparam int unsigned GroupBytes = GroupSize / 8;
  localparam int unsigned ByteAw     = $clog2(MapBytes);
  localparam int unsigned GrpW       = $clog2(NumGroups);
  localparam int unsigned GbW        = $clog2(GroupBytes);
  localparam int unsigned SlotW      = $clog2(PoolSlots);
  localparam int unsigned GcntW      = $clog2(GroupSize) + 1;
  localparam int unsigned TotW       = 11;
  localparam int unsigned OffW       = 18;

  typedef enum logic [1:0] {
    OpAlloc  = 2'd0,
    OpFree   = 2'd1,
    OpHandle = 2'd2,
    OpNone   = 2'd3
  } op_e;

  localparam logic RegObjSize = 1'b0;
  localparam logic RegGroups  = 1'b1;

  typedef enum logic [3:0] {
    StIdle,
    StGrp,
    StScanRd,
    StScanChk,
    StDiv,
    StFreeRd,
    StFreeChk,
    StOut
  } state_e;

  // memory request between controller and map memory
  typedef struct packed {
    logic              rd;
    logic              wr;
    logic [ByteAw-1:0] addr;
    logic [7:0]        wdata;
  } mem_req_t;

endpackage

### hw/rtl/bsa_map_ram.sv
// used-bit map memory, one byte per entry, cleared by a sweep after reset
module bsa_map_ram (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  bsa_pkg::mem_req_t             req_i,
  output logic [7:0]                    rdata_o,
  output logic                          ready_o
);
  logic [7:0] mem [bsa_pkg::MapBytes];
  logic [bsa_pkg::ByteAw:0] clr_q, clr_d;

  assign ready_o = clr_q[bsa_pkg::ByteAw];
  assign clr_d   = ready_o ? clr_q : clr_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else begin
      clr_q <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!ready_o) begin
      mem[clr_q[bsa_pkg::ByteAw-1:0]] <= 8'h00;
    end else if (req_i.wr) begin
      mem[req_i.addr] <= req_i.wdata;
    end
    if (req_i.rd) begin
      rdata_o <= mem[req_i.addr];
    end
  end
endmodule

### hw/rtl/bsa_divider.sv
// restoring divider, offset by object size, one quotient bit a cycle
module bsa_divider (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [26:0] dividend_i,
  input  logic [8:0]  divisor_i,
  output logic        done_o,
  output logic [26:0] quot_o,
  output logic [8:0]  rem_o
);
  logic [26:0] q_q, q_d;
  logic [8:0]  r_q, r_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [9:0]  trial;

  assign trial  = {r_q, q_q[26]} - {1'b0, divisor_i};
  assign done_o = busy_q && (cnt_q == 5'd26);
  assign quot_o = q_d;
  assign rem_o  = r_d;

  always_comb begin
    q_d = q_q; r_d = r_q; cnt_d = cnt_q; busy_d = busy_q;
    if (start_i) begin
      q_d = dividend_i; r_d = '0; cnt_d = '0; busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[9]) begin
        r_d = trial[8:0];
        q_d = {q_q[25:0], 1'b1};
      end else begin
        r_d = {r_q[7:0], q_q[26]};
        q_d = {q_q[25:0], 1'b0};
      end
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd26) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d;
    r_q <= r_d;
  end
endmodule

### hw/rtl/bitmap_slot_allocator.sv
// top level of the bitmap slot allocator
// alloc: group check, then a byte scan (read, then check, per byte), then output;
//   straight to output when the pool is full or the op is unknown; handle and free
//   run the 27-step divider, then a free does a read-modify-write of the map byte
// throughput: one transaction at a time; input reopens the cycle after the result is taken
// reset: clear sweep of the map memory, tready low until done; counts cleared,
//   object_size 1, active_groups 4
module bitmap_slot_allocator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // op[1:0], offset[33:2], zero pad
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // ok[0], result_offset[18:1], used_total[29:19]
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [8:0]  cfg_wdata_i
);
  localparam int unsigned GW  = bsa_pkg::GrpW;

  bsa_pkg::state_e st_q, st_d;
  logic [8:0]  osz_q;
  logic [2:0]  agr_q;
  logic [bsa_pkg::GcntW-1:0] gcnt_q [bsa_pkg::NumGroups];
  logic [bsa_pkg::TotW-1:0]  tot_q, tot_d;
  logic [bsa_pkg::SlotW-1:0] last_q, last_d;
  logic [1:0]  op_q, op_d;
  logic [31:0] raw_q, raw_d;
  logic [GW-1:0]  g_q, g_d;
  logic [GW:0]    tries_q, tries_d;
  logic [bsa_pkg::GbW:0] b_q, b_d;
  logic        ok_q, ok_d;
  logic [bsa_pkg::OffW-1:0] res_q, res_d;
  logic        ovld_q, ovld_d;
  logic [bsa_pkg::SlotW-1:0] slot_q, slot_d;

  // effective config
  logic [8:0] size;
  logic [2:0] groups;
  assign size   = (osz_q == 9'd0) ? 9'd1 : (osz_q > 9'd256 ? 9'd256 : osz_q);
  assign groups = (agr_q == 3'd0) ? 3'd1 :
                  (agr_q > 3'(bsa_pkg::NumGroups) ? 3'(bsa_pkg::NumGroups) : agr_q);

  logic [11:0] cap;
  logic [19:0] limit;
  assign cap   = 12'(groups) * 12'(bsa_pkg::GroupSize);
  assign limit = 20'(cap) * 20'(size);

  bsa_pkg::mem_req_t req;
  logic [7:0] rdata;
  logic       mem_ready;
  bsa_map_ram u_ram (
    .clk_i, .rst_ni, .req_i(req), .rdata_o(rdata), .ready_o(mem_ready)
  );

  // divider starts at the accepting edge, so it takes the offset being captured
  logic        div_start, div_done;
  logic [26:0] quot;
  logic [8:0]  rem;
  bsa_divider u_div (
    .clk_i, .rst_ni, .start_i(div_start), .dividend_i(raw_d[26:0]),
    .divisor_i(size), .done_o(div_done), .quot_o(quot), .rem_o(rem)
  );

  logic        in_acc, in_range;
  logic [2:0]  lowbit;
  logic [7:0]  fmask;
  logic        gcnt_inc, gcnt_dec;
  logic [GW-1:0] gsel_q, gsel_d;
  logic [GW:0] gnext;
  logic [2:0]  last_grp;

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign in_range = !raw_q[31] && (raw_q < 32'(limit));
  assign s_axis_tready = (st_q == bsa_pkg::StIdle) && mem_ready && !ovld_q;
  assign m_axis_tvalid = ovld_q;
  assign m_axis_tdata  = {2'b00, tot_q, res_q, ok_q};
  assign gnext    = ({1'b0, g_q} + 1'b1 >= (GW+1)'(groups)) ? '0 : {1'b0, g_q} + 1'b1;
  assign last_grp = 3'(last_q[bsa_pkg::SlotW-1 -: GW]);

  always_comb begin
    lowbit = 3'd7;
    for (int i = 7; i >= 0; i--) begin
      if (!rdata[i]) lowbit = 3'(i);
    end
  end

  always_comb begin
    st_d = st_q; op_d = op_q; raw_d = raw_q; g_d = g_q; tries_d = tries_q;
    b_d = b_q; ok_d = ok_q; res_d = res_q; ovld_d = ovld_q; slot_d = slot_q;
    tot_d = tot_q; last_d = last_q; gsel_d = gsel_q;
    req = '0; div_start = 1'b0; gcnt_inc = 1'b0; gcnt_dec = 1'b0;
    fmask = 8'd1 << slot_q[2:0];
    if (ovld_q && m_axis_tready) ovld_d = 1'b0;
    unique case (st_q)
      bsa_pkg::StIdle: begin
        if (in_acc) begin
          op_d = s_axis_tdata[1:0];
          raw_d = s_axis_tdata[33:2];
          ok_d = 1'b0; res_d = '0;
          st_d = bsa_pkg::StOut;
          if (s_axis_tdata[1:0] == bsa_pkg::OpAlloc) begin
            g_d = (last_grp >= groups) ? '0 : last_grp[GW-1:0];
            tries_d = '0;
            if (12'(tot_q) < cap) st_d = bsa_pkg::StGrp;
          end else if (s_axis_tdata[1:0] == bsa_pkg::OpFree ||
                       s_axis_tdata[1:0] == bsa_pkg::OpHandle) begin
            st_d = bsa_pkg::StDiv;
            div_start = 1'b1;
          end
        end
      end
      bsa_pkg::StGrp: begin
        if (tries_q == (GW+1)'(groups)) begin
          st_d = bsa_pkg::StOut;
        end else if (gcnt_q[g_q] < bsa_pkg::GcntW'(bsa_pkg::GroupSize)) begin
          b_d = '0; st_d = bsa_pkg::StScanRd;
        end else begin
          g_d = gnext[GW-1:0];
          tries_d = tries_q + 1'b1;
        end
      end
      bsa_pkg::StScanRd: begin
        if (b_q[bsa_pkg::GbW]) begin
          st_d = bsa_pkg::StOut;
        end else begin
          req.rd = 1'b1;
          req.addr = {g_q, b_q[bsa_pkg::GbW-1:0]};
          st_d = bsa_pkg::StScanChk;
        end
      end
      bsa_pkg::StScanChk: begin
        req.addr = {g_q, b_q[bsa_pkg::GbW-1:0]};
        if (rdata == 8'hFF) begin
          b_d = b_q + 1'b1; st_d = bsa_pkg::StScanRd;
        end else begin
          req.wr = 1'b1;
          req.wdata = rdata | (8'd1 << lowbit);
          gsel_d = g_q; gcnt_inc = 1'b1;
          tot_d = tot_q + 1'b1;
          last_d = {g_q, b_q[bsa_pkg::GbW-1:0], lowbit};
          ok_d = 1'b1;
          res_d = bsa_pkg::OffW'(20'({g_q, b_q[bsa_pkg::GbW-1:0], lowbit}) * 20'(size));
          st_d = bsa_pkg::StOut;
        end
      end
      bsa_pkg::StDiv: begin
        if (div_done) begin
          if (op_q == bsa_pkg::OpHandle) begin
            if (in_range) begin
              ok_d = 1'b1;
              res_d = bsa_pkg::OffW'(raw_q - 32'(rem));
            end
            st_d = bsa_pkg::StOut;
          end else if (in_range && rem == 9'd0) begin
            slot_d = quot[bsa_pkg::SlotW-1:0];
            st_d = bsa_pkg::StFreeRd;
          end else begin
            st_d = bsa_pkg::StOut;
          end
        end
      end
      bsa_pkg::StFreeRd: begin
        req.rd = 1'b1;
        req.addr = slot_q[bsa_pkg::SlotW-1:3];
        st_d = bsa_pkg::StFreeChk;
      end
      bsa_pkg::StFreeChk: begin
        req.addr = slot_q[bsa_pkg::SlotW-1:3];
        if ((rdata & fmask) != 8'd0) begin
          req.wr = 1'b1;
          req.wdata = rdata & ~fmask;
          gsel_d = slot_q[bsa_pkg::SlotW-1 -: GW];
          gcnt_dec = 1'b1;
          if (tot_q != '0) tot_d = tot_q - 1'b1;
          ok_d = 1'b1;
        end
        st_d = bsa_pkg::StOut;
      end
      bsa_pkg::StOut: begin
        if (!ovld_q) begin
          ovld_d = 1'b1;
          st_d = bsa_pkg::StIdle;
        end
      end
      default: st_d = bsa_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= bsa_pkg::StIdle;
      osz_q  <= 9'd1;
      agr_q  <= 3'd4;
      tot_q  <= '0;
      last_q <= '0;
      ovld_q <= 1'b0;
      for (int i = 0; i < bsa_pkg::NumGroups; i++) gcnt_q[i] <= '0;
    end else begin
      st_q   <= st_d;
      tot_q  <= tot_d;
      last_q <= last_d;
      ovld_q <= ovld_d;
      if (gcnt_inc) gcnt_q[gsel_d] <= gcnt_q[gsel_d] + 1'b1;
      else if (gcnt_dec && gcnt_q[gsel_d] != '0) gcnt_q[gsel_d] <= gcnt_q[gsel_d] - 1'b1;
      if (cfg_we_i) begin
        if (cfg_idx_i == bsa_pkg::RegObjSize) osz_q <= cfg_wdata_i;
        else agr_q <= cfg_wdata_i[2:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d; raw_q <= raw_d; g_q <= g_d; tries_q <= tries_d; b_q <= b_d;
    ok_q <= ok_d; res_q <= res_d; slot_q <= slot_d; gsel_q <= gsel_d;
  end

  // a result never lands on top of one still waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovld_q && !m_axis_tready |=> ovld_q && $stable(m_axis_tdata))
    else $error("pending result lost");
  // the used count never moves outside a transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == bsa_pkg::StIdle |=> $stable(tot_q) || $past(in_acc))
    else $error("used count changed while idle");
  // a failed transaction reports a zero offset
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovld_q && !ok_q |-> res_q == '0)
    else $error("nonzero offset on failure");
endmodule
